// ===== hw/rtl/majority_mode_filter_3x3_macros.svh =====
// Assertion macros for the majority mode filter RTL.
`ifndef MAJORITY_MODE_FILTER_3X3_MACROS_SVH
`define MAJORITY_MODE_FILTER_3X3_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define MMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define MMF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMF_ASSERT(lbl, prop, msg)
`define MMF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/mmf_pkg.sv =====
// Types and constants of the 3x3 majority mode filter.
package mmf_pkg;

  localparam int CLASS_W       = 3;
  localparam int NUM_CLASS     = 8;
  localparam int WIN_CELLS     = 9;
  localparam int WIN_CENTER    = 4;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd64;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd64;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_TILE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic               pinned;
    logic [CLASS_W-1:0] cls;
  } cell_t;

  // Row-major 3x3 window, index row*3 + column.
  typedef cell_t [WIN_CELLS-1:0] window_t;

  // Which window rows and columns lie inside the frame.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } edge_mask_t;

endpackage

// ===== hw/rtl/mmf_vote.sv =====
// Mode vote over the in-frame cells of a 3x3 window, pinned center kept.
module mmf_vote
  import mmf_pkg::*;
(
  input  window_t            win,
  input  edge_mask_t         mask,
  output logic [CLASS_W-1:0] vote_class
);

  logic [3:0]         cnt [NUM_CLASS];
  logic [WIN_CELLS-1:0] ok;
  logic [2:0]         row_ok;
  logic [2:0]         col_ok;

  assign row_ok = {mask.bot_ok, 1'b1, mask.top_ok};
  assign col_ok = {mask.right_ok, 1'b1, mask.left_ok};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ok[r*3+c] = row_ok[r] & col_ok[c];
      end
    end
  end

  // Count each class among the cells inside the frame.
  always_comb begin
    for (int k = 0; k < NUM_CLASS; k++) begin
      cnt[k] = '0;
      for (int i = 0; i < WIN_CELLS; i++) begin
        if (ok[i] && (win[i].cls == CLASS_W'(k))) begin
          cnt[k] = cnt[k] + 4'd1;
        end
      end
    end
  end

  // Strictly greater wins, so a tie keeps the lower class.
  always_comb begin
    logic [CLASS_W-1:0] best;
    logic [3:0]         best_cnt;
    best     = win[WIN_CENTER].cls;
    best_cnt = '0;
    for (int k = 0; k < NUM_CLASS; k++) begin
      if (cnt[k] > best_cnt) begin
        best_cnt = cnt[k];
        best     = CLASS_W'(k);
      end
    end
    vote_class = win[WIN_CENTER].pinned ? win[WIN_CENTER].cls : best;
  end

endmodule

// ===== hw/rtl/majority_mode_filter_3x3.sv =====
// Top level of the 3x3 majority mode filter with line stores and window.
//
// Usage: send tiles in raster order on the in_ stream, one beat per tile,
// in_tuser = 0 with class and pinned flag in in_tdata. Each filtered tile
// comes out on the out_ stream; out_tlast marks the last tile of a frame.
// Results trail the input by frame_width + 1 tiles, so once the last tile of
// a frame is in, send flush beats (in_tuser = 1) to drain the frame; a flush
// at any other place, or with nothing held, is dropped without a result.
// Tiles of the next frame may follow the last tile directly instead.
// Throughput: one beat per cycle unless a staged result waits on out_tready.
// A releasing beat goes through the stage register, then the result register.
// Address and counter work happens at the input edge, the line store read
// data and the window update sit in one stage, the vote feeds the result
// register. The line stores are MAX_WIDTH-deep memories, one write and one
// read per cycle; a write and read of the same column in back-to-back beats
// is forwarded.
// Reset clears counters, window and valid flags; line store contents stay
// undefined. When out_tready is low the result register holds; beats that
// release nothing flow on, one releasing beat enters the stage register and
// then in_tready drops until the result is taken.
// Write frame_width / frame_height on the cfg_ port only while idle.
`include "majority_mode_filter_3x3_macros.svh"
module majority_mode_filter_3x3
  import mmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [2:0] tile_class, [3] pinned, [7:4] zero
  input  logic [0:0]            in_tuser,   // [0] operation
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [2:0] out_class, [3] out_pinned, [7:4] zero
  output logic                  out_tlast   // frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_WIDTH + 2);
  localparam int LW = ((HW > FW_W) ? HW : FW_W) + 1;

  typedef struct packed {
    logic          is_tile;
    cell_t         tile;
    logic [AW-1:0] addr;
    logic          emit;
    edge_mask_t    mask;
    logic          frame_end;
  } s1_t;

  // Configuration registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  // Position and fill counters
  logic [AW-1:0]   ic_r, ic_nxt, oc_r, oc_nxt;
  logic [FH_W-1:0] ir_r, ir_nxt, or_r, or_nxt;
  logic [HW-1:0]   held_r, held_nxt;

  // Stage register and line store read data
  logic     s1_valid_r, s1_valid_nxt;
  s1_t      s1_r, s1_nxt;
  cell_t    up_rd_r, mid_rd_r;
  logic     fwd_r, fwd_nxt;
  cell_t    fwd_u_r, fwd_m_r;

  // Line stores
  cell_t upper_mem  [MAX_WIDTH];
  cell_t middle_mem [MAX_WIDTH];

  // Window and result register
  window_t            win_r, win_nxt;
  logic               out_valid_r;
  cell_t              out_cell_r;
  logic               out_last_r;
  logic [CLASS_W-1:0] vote_class;

  // Frame geometry, clamped counters
  logic [LW-1:0]   fw_x, w_eff;
  logic [FH_W-1:0] h_eff;
  logic [AW-1:0]   ic_c, oc_c, ic_adv, oc_adv, rd_addr;
  logic [FH_W-1:0] ir_c, or_c, ir_adv, or_adv;
  logic            ic_last, oc_last, ir_last, or_last;

  logic  in_fire, is_tile, flush_ok, emit0, take, s1_adv, mem_we;
  cell_t s1_u, s1_m, s1_b;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective width and height: zero acts as one, width clamped to the line store depth.
  always_comb begin
    fw_x = LW'(frame_width_r);
    if (fw_x == '0) begin
      w_eff = LW'(1);
    end else if (fw_x > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = fw_x;
    end
    h_eff = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
  end

  // Restart any counter that lies outside the current frame.
  always_comb begin
    ic_c    = (LW'(ic_r) >= w_eff) ? '0 : ic_r;
    oc_c    = (LW'(oc_r) >= w_eff) ? '0 : oc_r;
    ir_c    = (ir_r >= h_eff) ? '0 : ir_r;
    or_c    = (or_r >= h_eff) ? '0 : or_r;
    ic_last = (LW'(ic_c) == (w_eff - LW'(1)));
    oc_last = (LW'(oc_c) == (w_eff - LW'(1)));
    ir_last = (ir_c == (h_eff - FH_W'(1)));
    or_last = (or_c == (h_eff - FH_W'(1)));
    ic_adv  = ic_last ? '0 : ic_c + AW'(1);
    oc_adv  = oc_last ? '0 : oc_c + AW'(1);
    ir_adv  = ir_last ? '0 : ir_c + FH_W'(1);
    or_adv  = or_last ? '0 : or_c + FH_W'(1);
  end

  // ---------------------------------------------------------------------
  // Input side: decide at the accepting edge what the beat does
  // ---------------------------------------------------------------------
  assign in_fire  = in_tvalid & in_tready;
  assign is_tile  = (in_tuser[0] == OP_TILE);
  // A flush only counts at the frame start with results still held.
  assign flush_ok = (ic_c == '0) && (ir_c == '0) && (held_r != '0);
  // A tile releases a result once at least width+1 tiles are held.
  assign emit0    = is_tile ? (LW'(held_r) >= (w_eff + LW'(1))) : 1'b1;
  assign take     = in_fire & (is_tile | flush_ok);
  // A flush fetches the column right of the next result to slide in.
  assign rd_addr  = is_tile ? ic_c : oc_adv;

  always_comb begin
    ic_nxt   = ic_r;
    ir_nxt   = ir_r;
    oc_nxt   = oc_r;
    or_nxt   = or_r;
    held_nxt = held_r;
    if (in_fire) begin
      ic_nxt = ic_c;
      ir_nxt = ir_c;
      oc_nxt = oc_c;
      or_nxt = or_c;
      if (is_tile) begin
        ic_nxt = ic_adv;
        if (ic_last) begin
          ir_nxt = ir_adv;
        end
        if (!emit0) begin
          held_nxt = held_r + HW'(1);
        end
      end else if (flush_ok) begin
        held_nxt = held_r - HW'(1);
      end
      if (take && emit0) begin
        oc_nxt = oc_adv;
        if (oc_last) begin
          or_nxt = or_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r   <= '0;
      ir_r   <= '0;
      oc_r   <= '0;
      or_r   <= '0;
      held_r <= '0;
    end else begin
      ic_r   <= ic_nxt;
      ir_r   <= ir_nxt;
      oc_r   <= oc_nxt;
      or_r   <= or_nxt;
      held_r <= held_nxt;
    end
  end

  // Stage record; the mask describes the result position the beat releases.
  always_comb begin
    s1_nxt.is_tile        = is_tile;
    s1_nxt.tile.pinned    = in_tdata[3];
    s1_nxt.tile.cls       = in_tdata[2:0];
    s1_nxt.addr           = rd_addr;
    s1_nxt.emit           = emit0;
    s1_nxt.mask.top_ok    = (or_c != '0);
    s1_nxt.mask.bot_ok    = !or_last;
    s1_nxt.mask.left_ok   = (oc_c != '0);
    s1_nxt.mask.right_ok  = !oc_last;
    s1_nxt.frame_end      = or_last & oc_last;
  end

  // ---------------------------------------------------------------------
  // Stage: advance unless a result must wait for the result register
  // ---------------------------------------------------------------------
  assign s1_adv    = s1_valid_r & (!s1_r.emit | !out_valid_r | out_tready);
  assign in_tready = !s1_valid_r | s1_adv;
  assign mem_we    = s1_adv & s1_r.is_tile;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Forward the column the stage writes at the edge the next beat reads it.
  assign fwd_nxt = mem_we & (s1_r.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r    <= s1_nxt;
      fwd_r   <= fwd_nxt;
      fwd_u_r <= s1_m;
      fwd_m_r <= s1_r.tile;
    end
  end

  // Line stores: the middle row drops into the upper one, the tile into the middle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[s1_r.addr]  <= s1_m;
      middle_mem[s1_r.addr] <= s1_r.tile;
    end
    if (take) begin
      up_rd_r  <= upper_mem[rd_addr];
      mid_rd_r <= middle_mem[rd_addr];
    end
  end

  assign s1_u = fwd_r ? fwd_u_r : up_rd_r;
  assign s1_m = fwd_r ? fwd_m_r : mid_rd_r;
  assign s1_b = s1_r.is_tile ? s1_r.tile : '0;

  // Slide the window left and insert the fetched column on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = s1_u;
    win_nxt[5] = s1_m;
    win_nxt[8] = s1_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  mmf_vote u_vote (
    .win        (win_nxt),
    .mask       (s1_r.mask),
    .vote_class (vote_class)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.emit) begin
      out_cell_r.cls    <= vote_class;
      out_cell_r.pinned <= win_nxt[WIN_CENTER].pinned;
      out_last_r        <= s1_r.frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cell_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `MMF_ASSERT_RST(a_reset_no_result, !rst_n |=> !out_tvalid, "result valid after reset")
  `MMF_ASSERT(a_flush_emits, s1_valid_r && !s1_r.is_tile |-> s1_r.emit,
              "accepted flush without a result")
  `MMF_ASSERT(a_stall_blocks_input,
              s1_valid_r && s1_r.emit && out_valid_r && !out_tready |-> !in_tready,
              "input taken while a staged result is blocked")
  `MMF_ASSERT(a_result_from_stage, $rose(out_tvalid) |-> $past(s1_valid_r && s1_r.emit),
              "result appeared without a staged emit")

endmodule
